>>> hdl/assert_macros.svh
// Assertion macros shared by the mesh edge dedup RTL.
// Depends on nothing; users must provide signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MED_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define MED_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/med_pkg.sv
// Shared types and constants for the mesh edge dedup block.
// Depends on nothing; used by med_dist and mesh_edge_dedup.
package med_pkg;

   localparam int VertexAw   = 10;
   localparam int VertexNum  = 1 << VertexAw;
   localparam int EdgeAw     = 10;
   localparam int MaxEdges   = 1 << EdgeAw;
   localparam int CountW     = EdgeAw + 1;
   localparam int CoordW     = 18;
   localparam int DiffW      = CoordW + 1;
   localparam int SumSqW     = 2 * DiffW;
   localparam int RootW      = SumSqW / 2;
   localparam int RootSteps  = SumSqW / 2;
   localparam int PairSumW   = RootW + 1;
   localparam int ThreshW    = 18;
   localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(41);

   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic OP_LOAD       = 1'b0;
   localparam logic OP_FACE       = 1'b1;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic [VertexAw-1:0] v_start;
      logic [VertexAw-1:0] v_stop;
   } edge_type;

endpackage

>>> hdl/mesh_edge_dedup.sv
// Top level of the mesh edge dedup block: vertex and edge memories,
// scan sequencer, result register and register port.
// Depends on med_pkg, med_dist and assert_macros.svh.
//
// Usage: a request with opcode load writes a vertex position into the
// vertex memory and produces no result. A request with opcode face gives
// the next vertex of the open face; face_end closes the face. Each new
// edge yields one result, and a closing vertex yields the wrap edge as a
// second result; last_result marks the final result of a request.
// Each candidate edge is checked against every stored edge. Per stored
// entry it reads the edge and its two vertices, then makes up to four
// distance runs (start, four multiplies, 19 root steps, hand-over); a
// duplicate ends the scan early. The block handles one request at a time:
// req_ready is high only while idle, and it stays low until the last result
// has been taken. A result is held in the output register while rsp_ready is low.
// Reset clears the edge count, face state and threshold (41); memory
// contents are undefined until written, and no clearing pass is run.
// The threshold register sits at byte address 0. The user must write it while idle; the block does not enforce it.
`include "assert_macros.svh"

module mesh_edge_dedup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic [med_pkg::VertexAw-1:0]         req_vertex_index,
   input  logic signed [med_pkg::CoordW-1:0]    req_pos_x,
   input  logic signed [med_pkg::CoordW-1:0]    req_pos_y,
   input  logic signed [med_pkg::CoordW-1:0]    req_pos_z,
   input  logic                                 req_face_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [med_pkg::VertexAw-1:0]         rsp_edge_start,
   output logic [med_pkg::VertexAw-1:0]         rsp_edge_stop,
   output logic                                 rsp_edge_added,
   output logic                                 rsp_table_full,
   output logic [med_pkg::CountW-1:0]           rsp_edge_total,
   output logic                                 rsp_last_result,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_LD_S, S_LD_E, S_LD_PE, S_SCAN, S_EWAIT, S_Q1, S_Q2, S_Q3,
      S_DIST, S_DWAIT, S_DECIDE, S_OUT
   } state_type;

   state_type                          state_ff;
   logic [med_pkg::ThreshW-1:0]        thresh_ff;
   logic [med_pkg::CountW-1:0]         count_ff;
   logic [med_pkg::VertexAw-1:0]       first_ff, prev_ff;
   logic                               inside_ff;
   logic [med_pkg::VertexAw-1:0]       s_ff, e_ff;
   logic                               last_ff, second_ff, red_ff;
   logic [med_pkg::CountW-1:0]         idx_ff;
   logic [1:0]                         pair_ff;
   logic [med_pkg::PairSumW-1:0]       sum_ff, sum_in;

   // Memories and their registered read data.
   med_pkg::vertex_type                vmem [med_pkg::VertexNum];
   med_pkg::edge_type                  emem [med_pkg::MaxEdges];
   logic [med_pkg::VertexAw-1:0]       vaddr_ff;
   med_pkg::vertex_type                vrd_ff, ps_ff, pe_ff, qs_ff, qe_ff;
   med_pkg::edge_type                  erd_ff;
   logic                               vwr_en;
   logic                               ewr_en;
   med_pkg::edge_type                  ewr_data;

   med_pkg::vertex_type                da, db;
   logic                               dstart, ddone;
   logic [med_pkg::RootW-1:0]          dval;

   logic                               req_fire, csr_wr;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign vwr_en    = req_fire && (req_opcode == med_pkg::OP_LOAD);

   // Vertex memory: written by load requests, read one address a cycle.
   always_ff @(posedge clock) begin
      if (vwr_en) vmem[req_vertex_index] <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
      vrd_ff <= vmem[vaddr_ff];
   end

   // Edge memory: appended at the decision step, read along the scan.
   assign ewr_en   = (state_ff == S_DECIDE) && !red_ff
                     && (count_ff < med_pkg::CountW'(med_pkg::MaxEdges));
   assign ewr_data = '{v_start: s_ff, v_stop: e_ff};

   always_ff @(posedge clock) begin
      if (ewr_en) emem[count_ff[med_pkg::EdgeAw-1:0]] <= ewr_data;
      erd_ff <= emem[idx_ff[med_pkg::EdgeAw-1:0]];
   end

   // Operand pairs in the order of the reference comparison: straight
   // orientation first, then the flipped one.
   always_comb begin
      case (pair_ff)
         2'd0:    begin da = ps_ff; db = qs_ff; end
         2'd1:    begin da = pe_ff; db = qe_ff; end
         2'd2:    begin da = ps_ff; db = qe_ff; end
         default: begin da = pe_ff; db = qs_ff; end
      endcase
   end

   assign dstart = (state_ff == S_DIST);
   assign sum_in = (pair_ff[0] ? sum_ff : '0) + med_pkg::PairSumW'(dval);

   med_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart),
      .pnt_a    (da),
      .pnt_b    (db),
      .done     (ddone),
      .root_out (dval)
   );

   // Register port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == med_pkg::REG_THRESHOLD);
   assign prdata = (paddr[2] == med_pkg::REG_THRESHOLD) ? 32'(thresh_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= med_pkg::ThreshReset;
      end else if (csr_wr) begin
         thresh_ff <= pwdata[med_pkg::ThreshW-1:0];
      end
   end

   // Sequencer: holds state, face bookkeeping and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         first_ff  <= '0;
         prev_ff   <= '0;
         inside_ff <= 1'b0;
         second_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_opcode == med_pkg::OP_FACE)) begin
                  if (!inside_ff) begin
                     first_ff <= req_vertex_index;
                     prev_ff  <= req_vertex_index;
                     if (req_face_end) begin
                        // A one-vertex face gives its self edge.
                        s_ff      <= req_vertex_index;
                        e_ff      <= req_vertex_index;
                        last_ff   <= 1'b1;
                        second_ff <= 1'b0;
                        vaddr_ff  <= req_vertex_index;
                        state_ff  <= S_LD_S;
                     end else begin
                        inside_ff <= 1'b1;
                     end
                  end else begin
                     s_ff      <= prev_ff;
                     e_ff      <= req_vertex_index;
                     last_ff   <= !req_face_end;
                     second_ff <= req_face_end;
                     prev_ff   <= req_vertex_index;
                     vaddr_ff  <= prev_ff;
                     if (req_face_end) inside_ff <= 1'b0;
                     state_ff  <= S_LD_S;
                  end
               end
            end
            S_LD_S: begin
               vaddr_ff <= e_ff;
               state_ff <= S_LD_E;
            end
            S_LD_E: begin
               ps_ff    <= vrd_ff;
               state_ff <= S_LD_PE;
            end
            S_LD_PE: begin
               pe_ff    <= vrd_ff;
               idx_ff   <= '0;
               red_ff   <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               state_ff <= (idx_ff == count_ff) ? S_DECIDE : S_EWAIT;
            end
            S_EWAIT: begin
               vaddr_ff <= erd_ff.v_start;
               state_ff <= S_Q1;
            end
            S_Q1: begin
               vaddr_ff <= erd_ff.v_stop;
               state_ff <= S_Q2;
            end
            S_Q2: begin
               qs_ff    <= vrd_ff;
               state_ff <= S_Q3;
            end
            S_Q3: begin
               qe_ff    <= vrd_ff;
               pair_ff  <= 2'd0;
               state_ff <= S_DIST;
            end
            S_DIST: begin
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (ddone) begin
                  sum_ff  <= sum_in;
                  pair_ff <= pair_ff + 2'd1;
                  if (pair_ff[0] && (sum_in < med_pkg::PairSumW'(thresh_ff))) begin
                     red_ff   <= 1'b1;
                     state_ff <= S_DECIDE;
                  end else if (pair_ff == 2'd3) begin
                     idx_ff   <= idx_ff + med_pkg::CountW'(1);
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_DIST;
                  end
               end
            end
            S_DECIDE: begin
               rsp_edge_start  <= s_ff;
               rsp_edge_stop   <= e_ff;
               rsp_last_result <= last_ff;
               rsp_edge_added  <= ewr_en;
               rsp_table_full  <= !red_ff && !ewr_en;
               rsp_edge_total  <= count_ff + med_pkg::CountW'(ewr_en);
               if (ewr_en) count_ff <= count_ff + med_pkg::CountW'(1);
               rsp_valid       <= 1'b1;
               state_ff        <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  if (second_ff) begin
                     // Wrap edge from the closing vertex back to the first.
                     s_ff      <= e_ff;
                     e_ff      <= first_ff;
                     last_ff   <= 1'b1;
                     second_ff <= 1'b0;
                     vaddr_ff  <= e_ff;
                     state_ff  <= S_LD_S;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The block never takes a request while a result is pending.
   `MED_ASSERT_ALWAYS(a_no_overlap, !(req_ready && rsp_valid))
   // A full flag only appears with the edge table at capacity.
   `MED_ASSERT_IMPLY(a_full_count, rsp_valid && rsp_table_full,
                     rsp_edge_total == med_pkg::CountW'(med_pkg::MaxEdges))
   // An edge is never both appended and dropped for lack of room.
   `MED_ASSERT_IMPLY(a_add_xor_full, rsp_valid && rsp_edge_added, !rsp_table_full)

endmodule

>>> hdl/med_dist.sv
// Iterative Euclidean distance unit: one shared multiplier, then a
// bit-pair integer square root. Depends on med_pkg.
module med_dist (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  med_pkg::vertex_type            pnt_a,
   input  med_pkg::vertex_type            pnt_b,
   output logic                           done,
   output logic [med_pkg::RootW-1:0]      root_out
);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROOT} state_type;

   state_type                          state_ff;
   logic [1:0]                         mstep_ff;
   logic [4:0]                         rstep_ff;
   med_pkg::vertex_type                a_ff, b_ff;
   logic signed [med_pkg::DiffW-1:0]   diff;
   logic signed [med_pkg::SumSqW-1:0]  prod_ff;
   logic [med_pkg::SumSqW-1:0]         acc_ff, acc_in;
   logic [med_pkg::SumSqW-1:0]         res_ff, bit_ff, trial;
   logic                               done_ff;

   always_comb begin
      case (mstep_ff)
         2'd0:    diff = med_pkg::DiffW'(a_ff.x) - med_pkg::DiffW'(b_ff.x);
         2'd1:    diff = med_pkg::DiffW'(a_ff.y) - med_pkg::DiffW'(b_ff.y);
         default: diff = med_pkg::DiffW'(a_ff.z) - med_pkg::DiffW'(b_ff.z);
      endcase
   end

   assign acc_in = (mstep_ff == 2'd1) ? $unsigned(prod_ff) : acc_ff + $unsigned(prod_ff);
   assign trial  = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         mstep_ff <= 2'd0;
         rstep_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_ff     <= pnt_a;
                  b_ff     <= pnt_b;
                  mstep_ff <= 2'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= diff * diff;
               mstep_ff <= mstep_ff + 2'd1;
               if (mstep_ff != 2'd0) acc_ff <= acc_in;
               if (mstep_ff == 2'd3) begin
                  res_ff   <= '0;
                  bit_ff   <= med_pkg::SumSqW'(1) << (med_pkg::SumSqW - 2);
                  rstep_ff <= '0;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (acc_ff >= trial) begin
                  acc_ff <= acc_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff   <= bit_ff >> 2;
               rstep_ff <= rstep_ff + 5'd1;
               if (rstep_ff == 5'(med_pkg::RootSteps - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign root_out = res_ff[med_pkg::RootW-1:0];

endmodule

>>> sim/tb_mesh_edge_dedup.sv
// Self-checking testbench for mesh_edge_dedup: vertex loads and face streams in, edge results out.
// A scoreboard class predicts each result, including duplicate filtering under several thresholds.
// Depends on med_pkg and the mesh_edge_dedup RTL.

class edge_scoreboard;
   typedef struct {
      logic [med_pkg::VertexAw-1:0] first;
      logic [med_pkg::VertexAw-1:0] second;
      logic                         added;
      logic                         full;
      logic [med_pkg::CountW-1:0]   total;
      logic                         last;
   } edge_result_type;

   med_pkg::vertex_type positions [med_pkg::VertexNum];
   med_pkg::edge_type   stored [med_pkg::MaxEdges];
   int unsigned         edge_count;
   logic [med_pkg::VertexAw-1:0] first_vtx, prev_vtx;
   bit                  face_open;
   int unsigned         threshold;
   edge_result_type     pending [$];
   int                  errors;
   int                  results_seen;
   int                  edges_added;

   function new();
      edge_count = 0;
      face_open  = 0;
      first_vtx  = '0;
      prev_vtx   = '0;
      threshold  = 41;
      errors     = 0;
      results_seen = 0;
      edges_added  = 0;
   endfunction

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned span(med_pkg::vertex_type a, med_pkg::vertex_type b);
      longint dx, dy, dz;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      dz = longint'(a.z) - longint'(b.z);
      return int_root(dx * dx + dy * dy + dz * dz);
   endfunction

   // An edge is a duplicate if some stored edge lies close in either orientation.
   function automatic bit is_duplicate(logic [med_pkg::VertexAw-1:0] s,
                                       logic [med_pkg::VertexAw-1:0] e);
      med_pkg::vertex_type ps, pe, qs, qe;
      ps = positions[s];
      pe = positions[e];
      for (int i = 0; i < edge_count; i++) begin
         qs = positions[stored[i].v_start];
         qe = positions[stored[i].v_stop];
         if (span(ps, qs) + span(pe, qe) < threshold) return 1;
         if (span(ps, qe) + span(pe, qs) < threshold) return 1;
      end
      return 0;
   endfunction

   function automatic void add_edge(logic [med_pkg::VertexAw-1:0] s,
                                    logic [med_pkg::VertexAw-1:0] e, bit last);
      edge_result_type r;
      r.first = s;
      r.second = e;
      r.added = 0;
      r.full = 0;
      if (!is_duplicate(s, e)) begin
         if (edge_count < med_pkg::MaxEdges) begin
            stored[edge_count].v_start = s;
            stored[edge_count].v_stop  = e;
            edge_count++;
            r.added = 1;
         end else begin
            r.full = 1;
         end
      end
      r.total = edge_count[med_pkg::CountW-1:0];
      r.last = last;
      pending.insert(pending.size(), r);
   endfunction

   function automatic void note_request(logic op, logic [med_pkg::VertexAw-1:0] idx,
                                        med_pkg::vertex_type pos, logic fend);
      if (op == med_pkg::OP_LOAD) begin
         positions[idx] = pos;
      end else if (!face_open) begin
         first_vtx = idx;
         prev_vtx  = idx;
         if (fend) add_edge(idx, idx, 1);
         else face_open = 1;
      end else begin
         add_edge(prev_vtx, idx, !fend);
         prev_vtx = idx;
         if (fend) begin
            add_edge(idx, first_vtx, 1);
            face_open = 0;
         end
      end
   endfunction

   function automatic void check_result(logic [med_pkg::VertexAw-1:0] s,
                                        logic [med_pkg::VertexAw-1:0] e, logic added,
                                        logic full, logic [med_pkg::CountW-1:0] total,
                                        logic last);
      edge_result_type x;
      results_seen++;
      if (added === 1'b1) edges_added++;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result edge %0d->%0d", $time, s, e);
         errors++;
         return;
      end
      x = pending.pop_front();
      if (s !== x.first || e !== x.second || added !== x.added || full !== x.full ||
          total !== x.total || last !== x.last) begin
         $display("%0t: mismatch expected start=%0d stop=%0d added=%0b full=%0b %s%0d last=%0b",
                  $time, x.first, x.second, x.added, x.full, "total=", x.total, x.last);
         $display("%0t:            actual start=%0d stop=%0d added=%0b full=%0b %s%0d last=%0b",
                  $time, s, e, added, full, "total=", total, last);
         errors++;
      end
   endfunction
endclass

module tb_mesh_edge_dedup;

   // Cycles without any handshake before the run is declared hung. The slowest
   // edge scans every stored edge to the end.
   localparam int HangLimit = 250000;
   // Vertices that faces draw from; kept small so that the edge table stays short.
   localparam int PoolSize = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = med_pkg::OP_LOAD;
   logic [med_pkg::VertexAw-1:0] req_vertex_index = '0;
   logic signed [med_pkg::CoordW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic req_face_end = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [med_pkg::VertexAw-1:0] rsp_edge_start, rsp_edge_stop;
   logic rsp_edge_added, rsp_table_full, rsp_last_result;
   logic [med_pkg::CountW-1:0] rsp_edge_total;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   edge_scoreboard board = new();
   bit  calm = 0;            // when set, neither side idles
   int  hang_count = 0;
   int  requests_sent = 0;
   bit  loaded [med_pkg::VertexNum];

   mesh_edge_dedup i_dut (.*);

   always #5 clock = ~clock;

   // The result side stalls at random, except during the calm stretch.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 36);
   end

   // Results are checked at the rising edge; the watchdog counts idle cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_edge_start, rsp_edge_stop, rsp_edge_added,
                               rsp_table_full, rsp_edge_total, rsp_last_result);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || psel)
            hang_count = 0;
         else
            hang_count++;
         if (hang_count >= HangLimit) begin
            $display("%0t: no handshake for %0d cycles", $time, HangLimit);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Send one request, idling first at random. The caller returns at a falling edge.
   task automatic send_request(logic op, logic [med_pkg::VertexAw-1:0] idx,
                               logic signed [med_pkg::CoordW-1:0] x,
                               logic signed [med_pkg::CoordW-1:0] y,
                               logic signed [med_pkg::CoordW-1:0] z, logic fend);
      med_pkg::vertex_type pos;
      if (!calm && $urandom_range(99) < 36) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_vertex_index = idx;
      req_pos_x = x;
      req_pos_y = y;
      req_pos_z = z;
      req_face_end = fend;
      do @(posedge clock); while (!req_ready);
      pos.x = x;
      pos.y = y;
      pos.z = z;
      board.note_request(op, idx, pos, fend);
      if (op == med_pkg::OP_LOAD) loaded[idx] = 1;
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic load_vertex(int idx, int x, int y, int z);
      send_request(med_pkg::OP_LOAD, med_pkg::VertexAw'(idx), med_pkg::CoordW'(x),
                   med_pkg::CoordW'(y), med_pkg::CoordW'(z), 1'($urandom_range(1)));
   endtask

   // Face requests carry random junk in the position fields, which the block ignores.
   task automatic face_vertex(int idx, bit fend);
      send_request(med_pkg::OP_FACE, med_pkg::VertexAw'(idx), med_pkg::CoordW'($urandom),
                   med_pkg::CoordW'($urandom), med_pkg::CoordW'($urandom), fend);
   endtask

   // Wait until every expected result has arrived, then let the block settle.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle, then a read back.
   task automatic write_threshold(logic [31:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = 3'(4 * med_pkg::REG_THRESHOLD);
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata[med_pkg::ThreshW-1:0] !== value[med_pkg::ThreshW-1:0]) begin
         $display("%0t: threshold read back expected %0d actual %0d",
                  $time, value[med_pkg::ThreshW-1:0], prdata[med_pkg::ThreshW-1:0]);
         board.errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      board.threshold = value[med_pkg::ThreshW-1:0];
   endtask

   function automatic int pool_vertex();
      int v;
      do v = $urandom_range(PoolSize - 1); while (!loaded[v]);
      return v;
   endfunction

   // Random mix: mostly well-formed faces over the vertex pool, some loads.
   task automatic random_requests(int count);
      int n, len;
      n = 0;
      while (n < count) begin
         calm = (n >= count / 3) && (n < count / 3 + 12);
         if ($urandom_range(99) < 30) begin
            if ($urandom_range(3) == 0)
               load_vertex($urandom_range(med_pkg::VertexNum - 1), $urandom, $urandom,
                           $urandom);
            else
               load_vertex($urandom_range(PoolSize - 1),
                           4096 * $signed($urandom_range(8)) - 16384 + $urandom_range(24),
                           4096 * $signed($urandom_range(8)) - 16384 + $urandom_range(24),
                           4096 * $signed($urandom_range(8)) - 16384);
            n++;
         end else begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) face_vertex(pool_vertex(), k == len - 1);
            n += len;
         end
      end
      calm = 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Coordinate extremes, the top index and a load with face_end set.
      load_vertex(0, -131072, -131072, -131072);
      load_vertex(1, 131071, 131071, 131071);
      load_vertex(2, 0, 0, 0);
      load_vertex(3, 20, 0, 0);
      load_vertex(1023, 131071, -131072, 5);
      send_request(med_pkg::OP_LOAD, 10'd4, 18'sd30, 18'sd0, 18'sd0, 1'b1);
      // A one-vertex face closes at once and yields its self edge.
      face_vertex(2, 1);
      // A triangle, then the same triangle reversed, which is all duplicates.
      face_vertex(0, 0);
      face_vertex(1, 0);
      face_vertex(1023, 1);
      face_vertex(1023, 0);
      face_vertex(1, 0);
      face_vertex(0, 1);
      // A load inside an open face places a vertex that later edges then use.
      face_vertex(2, 0);
      load_vertex(5, 10, 10, 0);
      face_vertex(5, 0);
      face_vertex(4, 1);
      face_vertex(3, 1);
      wait_idle();

      // With a zero threshold nothing counts as a duplicate.
      write_threshold(0);
      face_vertex(2, 1);
      face_vertex(0, 0);
      face_vertex(1, 1);
      wait_idle();

      // With the largest threshold nearly everything does.
      write_threshold(32'h3FFFF);
      for (int v = 6; v < PoolSize; v++) load_vertex(v, 4096 * v, -4096 * v, 100 * v);
      face_vertex(6, 0);
      face_vertex(7, 1);
      wait_idle();

      write_threshold(41);
      random_requests(45);
      wait_idle();

      write_threshold(32'($urandom_range(1, 9000)));
      random_requests(30);
      wait_idle();

      write_threshold(0);
      random_requests(10);
      wait_idle();

      write_threshold(32'($urandom));
      random_requests(25);
      wait_idle();
      repeat (100) @(negedge clock);

      $display("Sent %0d requests across several threshold settings; checked %0d edge results.",
               requests_sent, board.results_seen);
      $display("Edges kept in the table: %0d.", board.edges_added);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
